@@ rtl/core/sjf_pkg.sv @@
// ----------------------------------------------------------------------------
// SJF scheduler package
// Shared widths, constants and the task table entry type.
// ----------------------------------------------------------------------------
package sjf_pkg;

    localparam int unsigned FIELD_W = 16;
    localparam int unsigned TIME_W  = 22;
    localparam int unsigned SPEED_W = 8;

    // Largest representable time; times saturate here.
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // Register index of the processor speed register.
    localparam logic REG_CPU_SPEED = 1'b0;

    // One entry of the task table memory.
    typedef struct packed {
        logic [FIELD_W-1:0] ident;
        logic [FIELD_W-1:0] rel;
        logic [FIELD_W-1:0] len;
    } t_task_ent;

endpackage

@@ rtl/core/sjf_div.sv @@
// ----------------------------------------------------------------------------
// SJF length divider
// Restoring divider, one quotient bit per cycle, for length / speed.
// ----------------------------------------------------------------------------
module sjf_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sjf_pkg::FIELD_W-1:0] i_dividend,
    input  logic [sjf_pkg::SPEED_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [sjf_pkg::FIELD_W-1:0] o_quot
);
    import sjf_pkg::*;

    localparam int unsigned BC_W = $clog2(FIELD_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [BC_W-1:0]      r_bits;
    logic [FIELD_W-1:0]   r_dq;
    logic [SPEED_W:0]     r_rem;
    logic [SPEED_W-1:0]   r_dvs;
    logic [SPEED_W:0]     n_shift;
    logic                 n_fit;

    // Shift in the next dividend bit and test the divisor against it.
    always_comb begin
        n_shift = {r_rem[SPEED_W-1:0], r_dq[FIELD_W-1]};
        n_fit   = (n_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bits <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bits <= BC_W'(FIELD_W);
                r_dq   <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_fit ? (n_shift - {1'b0, r_dvs}) : n_shift;
                r_dq   <= {r_dq[FIELD_W-2:0], n_fit};
                r_bits <= r_bits - 1'b1;
                if (r_bits == BC_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;

endmodule

@@ rtl/core/sjf_nonpreemptive_scheduler.sv @@
// ----------------------------------------------------------------------------
// Non-preemptive shortest-job-first scheduler
// Loads a task set into a table memory, then emits the dispatch schedule.
// ----------------------------------------------------------------------------
// Usage:
// Tasks enter one beat at a time on the input channel (i_valid / o_stall).
// A beat without final_task is stored. Tasks beyond
// MAX_TASKS are dropped. A beat with final_task set starts scheduling, and
// o_stall stays high until the last result beat has been taken.
// Each dispatch scans the loaded table through the single read port of the task
// memory, then runs a 16-step bit-serial divide of the length by cpu_speed.
// A result stays on the output registers while i_stall is high; the next
// scan starts once it is taken. The run_last beat closes the set and the
// table is emptied.
// Reset clears the done flags, task count and clock; the table memory holds
// no reset value and only loaded entries are rated. cpu_speed resets to 1
// and a written value of 0 is used as 1.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_scheduler #(
    parameter int unsigned MAX_TASKS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Task input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sjf_pkg::FIELD_W-1:0] i_task_ident,
    input  logic [sjf_pkg::FIELD_W-1:0] i_release_time,
    input  logic [sjf_pkg::FIELD_W-1:0] i_exec_length,
    input  logic                        i_final_task,
    // Schedule output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [sjf_pkg::FIELD_W-1:0] o_sched_ident,
    output logic [sjf_pkg::TIME_W-1:0]  o_start_time,
    output logic [sjf_pkg::TIME_W-1:0]  o_end_time,
    output logic                        o_run_last
);
    import sjf_pkg::*;

    localparam int unsigned CW = $clog2(MAX_TASKS + 1);
    localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [SPEED_W-1:0]   r_speed;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_k;
    logic [CW-1:0]        r_scan;
    logic [TIME_W-1:0]    r_clock;
    logic [MAX_TASKS-1:0] r_done;

    // Task table memory with registered read.
    t_task_ent            r_mem [MAX_TASKS];
    t_task_ent            r_rd;
    logic                 r_chk_vld;
    logic [IW-1:0]        r_chk_idx;

    // Best candidates of the current scan.
    logic                 r_have_r;
    logic [FIELD_W-1:0]   r_r_len;
    logic [FIELD_W-1:0]   r_r_rel;
    logic [FIELD_W-1:0]   r_r_ident;
    logic [IW-1:0]        r_r_idx;
    logic                 r_have_w;
    logic [FIELD_W-1:0]   r_w_len;
    logic [FIELD_W-1:0]   r_w_rel;
    logic [FIELD_W-1:0]   r_w_ident;
    logic [IW-1:0]        r_w_idx;

    logic [TIME_W-1:0]    r_start;
    logic [FIELD_W-1:0]   r_pick_ident;

    logic                 in_acc;
    logic                 cfg_wr;
    logic                 is_ready;
    logic                 div_start;
    logic                 div_done;
    logic [FIELD_W-1:0]   div_quot;
    logic [FIELD_W-1:0]   div_len;
    logic [SPEED_W-1:0]   eff_speed;
    logic [TIME_W:0]      end_sum;
    logic [TIME_W-1:0]    end_sat;
    logic                 scan_end;

    assign in_acc   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CPU_SPEED) ? {24'd0, r_speed} : 32'd0;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_W'(1);
        end else if (cfg_wr && paddr[2] == REG_CPU_SPEED) begin
            r_speed <= pwdata[SPEED_W-1:0];
        end
    end

    // Table writes on load, reads during the scan.
    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < CW'(MAX_TASKS)) begin
            r_mem[r_count[IW-1:0]] <= '{ident: i_task_ident, rel: i_release_time,
                                       len: i_exec_length};
        end
        r_rd <= r_mem[r_scan[IW-1:0]];
    end

    // A not yet done entry has arrived once its release is due.
    assign is_ready  = ({{(TIME_W-FIELD_W){1'b0}}, r_rd.rel} <= r_clock);
    assign scan_end  = (r_state == S_SCAN) && (r_scan == r_count) && !r_chk_vld;
    assign div_start = scan_end;
    assign div_len   = r_have_r ? r_r_len : r_w_len;
    assign eff_speed = (r_speed == '0) ? SPEED_W'(1) : r_speed;

    sjf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_len),
        .i_divisor  (eff_speed),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // End time saturates at the largest time.
    assign end_sum = {1'b0, r_start} + (TIME_W+1)'(div_quot);
    assign end_sat = end_sum[TIME_W] ? TIME_MAX : end_sum[TIME_W-1:0];

    // Sequencer: load, scan, divide, present result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_k       <= '0;
            r_scan    <= '0;
            r_clock   <= '0;
            r_done    <= '0;
            r_chk_vld <= 1'b0;
            r_have_r  <= 1'b0;
            r_have_w  <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_count < CW'(MAX_TASKS)) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_final_task) begin
                            r_state  <= S_SCAN;
                            r_k      <= '0;
                            r_scan   <= '0;
                            r_clock  <= '0;
                            r_have_r <= 1'b0;
                            r_have_w <= 1'b0;
                        end
                    end
                end
                S_SCAN: begin
                    // Issue one read per cycle and rate the entry read last cycle.
                    if (r_scan != r_count) begin
                        r_chk_vld <= 1'b1;
                        r_chk_idx <= r_scan[IW-1:0];
                        r_scan    <= r_scan + 1'b1;
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                    if (r_chk_vld && !r_done[r_chk_idx]) begin
                        if (is_ready) begin
                            if (!r_have_r || r_rd.len < r_r_len ||
                                (r_rd.len == r_r_len && r_rd.rel < r_r_rel)) begin
                                r_have_r  <= 1'b1;
                                r_r_len   <= r_rd.len;
                                r_r_rel   <= r_rd.rel;
                                r_r_ident <= r_rd.ident;
                                r_r_idx   <= r_chk_idx;
                            end
                        end else begin
                            if (!r_have_w || r_rd.rel < r_w_rel ||
                                (r_rd.rel == r_w_rel && r_rd.len < r_w_len)) begin
                                r_have_w  <= 1'b1;
                                r_w_len   <= r_rd.len;
                                r_w_rel   <= r_rd.rel;
                                r_w_ident <= r_rd.ident;
                                r_w_idx   <= r_chk_idx;
                            end
                        end
                    end
                    if (scan_end) begin
                        // With nothing ready, time jumps to the earliest release.
                        if (r_have_r) begin
                            r_start      <= r_clock;
                            r_pick_ident <= r_r_ident;
                            r_done[r_r_idx] <= 1'b1;
                        end else begin
                            r_start      <= TIME_W'(r_w_rel);
                            r_pick_ident <= r_w_ident;
                            r_done[r_w_idx] <= 1'b1;
                        end
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_clock       <= end_sat;
                        o_valid       <= 1'b1;
                        o_sched_ident <= r_pick_ident;
                        o_start_time  <= r_start;
                        o_end_time    <= end_sat;
                        o_run_last    <= (r_k == r_count - 1'b1);
                        r_state       <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        if (o_run_last) begin
                            r_count <= '0;
                            r_clock <= '0;
                            r_done  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k      <= r_k + 1'b1;
                            r_scan   <= '0;
                            r_have_r <= 1'b0;
                            r_have_w <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_end_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_end_time >= o_start_time))
        else $error("end time before start time");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !o_valid)
        else $error("task accepted while a result is pending");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_run_last) |=> (r_count == '0 && r_done == '0))
        else $error("table not emptied after last dispatch");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count beyond table size");
`endif

endmodule
